// ----- src/t2_variate_inversion_unit_assert.svh -----
// Assertion macros for the t2 variate inversion unit
`ifndef T2_VARIATE_INVERSION_UNIT_ASSERT_SVH
`define T2_VARIATE_INVERSION_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define T2VI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define T2VI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/t2vi_pkg.sv -----
// Shared types and constants for the t2 variate inversion unit
package t2vi_pkg;
    localparam int OUT_WIDTH = 40;
    localparam int Q_WIDTH   = OUT_WIDTH + 1;

    typedef struct packed {
        logic valid;
        logic neg;      // result is negative
        logic special;  // sample was 0 or at least 1.0
        logic spec_pos; // special and at least 1.0
    } t_ctl;
endpackage

// ----- src/t2vi_stage.sv -----
// One bit of the restoring square-root-division search
module t2vi_stage #(
    parameter int UNIFORM_FRAC_BITS = 32,
    parameter int RESULT_FRAC_BITS  = 16,
    parameter int BIT_POS           = 40
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_adv,
    input  t2vi_pkg::t_ctl                                  i_ctl,
    input  logic [t2vi_pkg::Q_WIDTH-1:0]                    i_q,
    input  logic [t2vi_pkg::Q_WIDTH+2*UNIFORM_FRAC_BITS-1:0] i_p,
    input  logic [2*UNIFORM_FRAC_BITS+2*RESULT_FRAC_BITS-1:0] i_res,
    input  logic [2*UNIFORM_FRAC_BITS-1:0]                  i_den,
    output t2vi_pkg::t_ctl                                  o_ctl,
    output logic [t2vi_pkg::Q_WIDTH-1:0]                    o_q,
    output logic [t2vi_pkg::Q_WIDTH+2*UNIFORM_FRAC_BITS-1:0] o_p,
    output logic [2*UNIFORM_FRAC_BITS+2*RESULT_FRAC_BITS-1:0] o_res,
    output logic [2*UNIFORM_FRAC_BITS-1:0]                  o_den
);
    import t2vi_pkg::*;

    localparam int DW = 2 * UNIFORM_FRAC_BITS;
    localparam int TW = 2 * UNIFORM_FRAC_BITS + 2 * RESULT_FRAC_BITS;
    localparam int PW = Q_WIDTH + DW;
    localparam int XW = 2 * Q_WIDTH + DW + 1;

    t_ctl            r_ctl;
    logic [Q_WIDTH-1:0] r_q;
    logic [PW-1:0]   r_p;
    logic [TW-1:0]   r_res;
    logic [DW-1:0]   r_den;

    logic [XW-1:0]   w_term;
    logic            w_take;

    // (q + 2^b)^2 * D - q^2 * D = 2^(b+1) * q*D + 2^(2b) * D
    assign w_term = (XW'(i_p) << (BIT_POS + 1)) + (XW'(i_den) << (2 * BIT_POS));
    assign w_take = (w_term <= XW'(i_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_den <= i_den;
            if (w_take) begin
                r_q   <= i_q | (Q_WIDTH'(1) << BIT_POS);
                r_res <= i_res - TW'(w_term);
                r_p   <= i_p + (PW'(i_den) << BIT_POS);
            end else begin
                r_q   <= i_q;
                r_res <= i_res;
                r_p   <= i_p;
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_q   = r_q;
    assign o_p   = r_p;
    assign o_res = r_res;
    assign o_den = r_den;
endmodule

// ----- src/t2_variate_inversion_unit.sv -----
// Top level of the t2 variate inversion unit
// Turns one uniform sample u (fraction of 2^UNIFORM_FRAC_BITS, 2^UNIFORM_FRAC_BITS = 1.0)
// into a Student-t variate with two degrees of freedom, signed fixed point with
// RESULT_FRAC_BITS fraction bits in 40 bits, truncated toward zero.
// Input channel: i_valid / o_stall with i_uniform_sample. Output channel:
// o_valid / i_stall with o_variate and o_saturated.
// An item is taken every cycle unless the pipeline stalls. An item passes 44 registers:
// one for the input decode, one for the square and the product u(S-u), 41 search
// stages (one result bit each, add and compare only), and the output register.
// u = 0 gives the most negative code, u >= 1.0 the most positive, both saturated.
// Reset (synchronous, active low) clears all stage valid bits; payload is not reset.
// When the receiver stalls a waiting result, the whole pipeline holds and o_stall
// rises, so nothing is lost or repeated; it releases the cycle stall drops.
module t2_variate_inversion_unit #(
    parameter int UNIFORM_FRAC_BITS = 32,
    parameter int RESULT_FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [UNIFORM_FRAC_BITS:0]    i_uniform_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [t2vi_pkg::OUT_WIDTH-1:0] o_variate,
    output logic                          o_saturated
);
    import t2vi_pkg::*;

    localparam int UF = UNIFORM_FRAC_BITS;
    localparam int DW = 2 * UF;
    localparam int TW = 2 * UF + 2 * RESULT_FRAC_BITS;
    localparam int PW = Q_WIDTH + DW;
    localparam int NS = Q_WIDTH;

    logic w_adv;

    // input decode
    t_ctl            r_a_ctl;
    logic [UF-1:0]   r_a_u;
    logic [UF-1:0]   r_a_cmp;
    logic [UF-1:0]   r_a_mag;
    t_ctl            n_a_ctl;
    logic [UF:0]     w_two_u;
    logic [UF:0]     w_full;

    // square and product
    t_ctl            r_b_ctl;
    logic [TW-1:0]   r_b_tgt;
    logic [DW-1:0]   r_b_den;

    t_ctl               w_ctl [0:NS];
    logic [Q_WIDTH-1:0] w_q   [0:NS];
    logic [PW-1:0]      w_p   [0:NS];
    logic [TW-1:0]      w_res [0:NS];
    logic [DW-1:0]      w_den [0:NS];

    // output
    logic                 r_valid;
    logic [OUT_WIDTH-1:0] r_variate;
    logic                 r_sat;
    logic [OUT_WIDTH-1:0] w_var;
    logic                 w_sat;
    logic                 w_over;
    t_ctl                 w_fin;
    logic [Q_WIDTH-1:0]   w_qf;

    assign w_adv   = !(r_valid && i_stall);
    assign o_stall = r_valid && i_stall;

    assign w_full  = (UF + 1)'(1) << UF;
    assign w_two_u = {i_uniform_sample[UF-1:0], 1'b0};

    always_comb begin
        n_a_ctl.valid    = i_valid;
        n_a_ctl.spec_pos = i_uniform_sample[UF];
        n_a_ctl.special  = i_uniform_sample[UF] || (i_uniform_sample[UF-1:0] == '0);
        n_a_ctl.neg      = !i_uniform_sample[UF] && !i_uniform_sample[UF-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (w_adv) begin
            r_a_ctl <= n_a_ctl;
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_u   <= i_uniform_sample[UF-1:0];
            r_a_cmp <= UF'(w_full - (UF + 1)'(i_uniform_sample[UF-1:0]));
            r_a_mag <= n_a_ctl.neg ? UF'(w_full - w_two_u) : UF'(w_two_u - w_full);
            // d^2 * 2^(2F) and 2u(S-u)
            r_b_tgt <= TW'(r_a_mag * r_a_mag) << (2 * RESULT_FRAC_BITS);
            r_b_den <= DW'(r_a_u * r_a_cmp) << 1;
        end
    end

    assign w_ctl[0] = r_b_ctl;
    assign w_q[0]   = '0;
    assign w_p[0]   = '0;
    assign w_res[0] = r_b_tgt;
    assign w_den[0] = r_b_den;

    for (genvar k = 0; k < NS; k++) begin : g_bit
        t2vi_stage #(
            .UNIFORM_FRAC_BITS (UNIFORM_FRAC_BITS),
            .RESULT_FRAC_BITS  (RESULT_FRAC_BITS),
            .BIT_POS           (OUT_WIDTH - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctl   (w_ctl[k]),
            .i_q     (w_q[k]),
            .i_p     (w_p[k]),
            .i_res   (w_res[k]),
            .i_den   (w_den[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_q     (w_q[k+1]),
            .o_p     (w_p[k+1]),
            .o_res   (w_res[k+1]),
            .o_den   (w_den[k+1])
        );
    end

    assign w_fin = w_ctl[NS];
    assign w_qf  = w_q[NS];

    always_comb begin
        // clamp to 2^39 - 1 when positive, 2^39 when negative
        if (w_fin.neg) begin
            w_over = w_qf[OUT_WIDTH] ||
                     (w_qf[OUT_WIDTH-1] && (w_qf[OUT_WIDTH-2:0] != '0));
        end else begin
            w_over = w_qf[OUT_WIDTH] || w_qf[OUT_WIDTH-1];
        end
        if (w_fin.special) begin
            w_sat = 1'b1;
            w_var = w_fin.spec_pos ? {1'b0, {(OUT_WIDTH-1){1'b1}}}
                                   : {1'b1, {(OUT_WIDTH-1){1'b0}}};
        end else if (w_over) begin
            w_sat = 1'b1;
            w_var = w_fin.neg ? {1'b1, {(OUT_WIDTH-1){1'b0}}}
                              : {1'b0, {(OUT_WIDTH-1){1'b1}}};
        end else begin
            w_sat = 1'b0;
            w_var = w_fin.neg ? OUT_WIDTH'(-w_qf) : OUT_WIDTH'(w_qf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= w_fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_variate <= w_var;
            r_sat     <= w_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_variate   = r_variate;
    assign o_saturated = r_sat;
endmodule

// ----- src/t2vi_checker.sv -----
// Port-level checker for the t2 variate inversion unit, with its bind
`include "t2_variate_inversion_unit_assert.svh"

module t2vi_checker #(
    parameter int UNIFORM_FRAC_BITS = 32
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic [UNIFORM_FRAC_BITS:0] i_uniform_sample,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [39:0]                o_variate,
    input logic                       o_saturated
);
    `T2VI_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_variate) && $stable(o_saturated), "stalled item changed")
    `T2VI_ASSERT_NEXT(a_in_hold, i_valid && o_stall,
        i_valid && $stable(i_uniform_sample), "stalled input item changed")
    `T2VI_ASSERT_NOW(a_stall_only_full, o_stall, o_valid && i_stall,
        "input stalled without a held result")
    `T2VI_ASSERT_NOW(a_sat_pos, o_valid && o_saturated && !o_variate[39],
        o_variate[38:0] == '1, "positive saturation not at max code")
    `T2VI_ASSERT_NOW(a_sat_neg, o_valid && o_saturated && o_variate[39],
        o_variate[38:0] == '0, "negative saturation not at min code")
endmodule

bind t2_variate_inversion_unit t2vi_checker #(
    .UNIFORM_FRAC_BITS (UNIFORM_FRAC_BITS)
) u_t2vi_checker (.*);

// ----- test/t2_variate_inversion_checker.sv -----
// Checker for the t2 variate inversion unit: predicts each variate and compares
`timescale 1ns / 1ps
module t2_variate_inversion_checker #(
    parameter int UNIFORM_FRAC_BITS = 32,
    parameter int RESULT_FRAC_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic                                  o_stall,
    input  logic [UNIFORM_FRAC_BITS:0]            i_uniform_sample,
    input  logic                                  o_valid,
    input  logic                                  i_stall,
    input  logic signed [t2vi_pkg::OUT_WIDTH-1:0] o_variate,
    input  logic                                  o_saturated,
    output int                                    error_count,
    output int                                    pending_count
);
    import t2vi_pkg::*;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] variate;
        logic                        saturated;
    } t_variate_item;

    t_variate_item variate_queue[$];

    // Exact integer inversion: largest q with q^2*2u(S-u) <= d^2*2^(2F).
    function automatic t_variate_item predict_variate(logic [UNIFORM_FRAC_BITS:0] sample);
        logic [255:0] full, u, d, target, denom, c, q, pos_max, neg_max, lim;
        logic         neg;
        t_variate_item r;
        full = 256'd1 << UNIFORM_FRAC_BITS;
        u = {{(255-UNIFORM_FRAC_BITS){1'b0}}, sample};
        pos_max = (256'd1 << (OUT_WIDTH-1)) - 1;
        neg_max = 256'd1 << (OUT_WIDTH-1);
        if (u > full) u = full;
        r.saturated = 1'b0;
        if (u == 0) begin
            r.variate = {1'b1, {(OUT_WIDTH-1){1'b0}}};
            r.saturated = 1'b1;
        end else if (u == full) begin
            r.variate = {1'b0, {(OUT_WIDTH-1){1'b1}}};
            r.saturated = 1'b1;
        end else begin
            neg = (2*u) < full;
            d = neg ? full - 2*u : 2*u - full;
            target = (d * d) << (2*RESULT_FRAC_BITS);
            denom = (u * (full - u)) << 1;
            q = 0;
            for (int b = OUT_WIDTH; b >= 0; b--) begin
                c = q | (256'd1 << b);
                if (c * c * denom <= target) q = c;
            end
            lim = neg ? neg_max : pos_max;
            if (q > lim) begin
                q = lim;
                r.saturated = 1'b1;
            end
            r.variate = neg ? -q[OUT_WIDTH-1:0] : q[OUT_WIDTH-1:0];
        end
        return r;
    endfunction

    assign pending_count = variate_queue.size();

    initial error_count = 0;

    always @(posedge i_clk) begin
        t_variate_item exp_item;
        if (i_rst_n && i_valid && !o_stall)
            variate_queue.push_back(predict_variate(i_uniform_sample));
        if (i_rst_n && o_valid && !i_stall) begin
            if (variate_queue.size() == 0) begin
                $error("unexpected item: variate %0d saturated %0b", o_variate, o_saturated);
                error_count++;
            end else begin
                exp_item = variate_queue.pop_front();
                if (o_variate !== exp_item.variate) begin
                    $error("variate: expected %0d actual %0d", exp_item.variate, o_variate);
                    error_count++;
                end
                if (o_saturated !== exp_item.saturated) begin
                    $error("saturated: expected %0b actual %0b",
                           exp_item.saturated, o_saturated);
                    error_count++;
                end
            end
        end
    end
endmodule

// ----- test/t2_variate_inversion_unit_test.sv -----
// Testbench top for the t2 variate inversion unit: stimulus and verdict
`timescale 1ns / 1ps
module t2_variate_inversion_unit_test;
    import t2vi_pkg::*;

    localparam int UFB = 32;
    localparam int RANDOM_ITEMS = 1130;
    localparam int QUIET_ITEMS = 150;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [UFB:0]                  i_uniform_sample;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [OUT_WIDTH-1:0]   o_variate;
    logic                          o_saturated;
    int                            error_count;
    int                            pending_count;
    bit                            quiet_phase;

    t2_variate_inversion_unit uut (.*);

    t2_variate_inversion_checker checker_inst (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stall bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    task automatic send_sample(logic [UFB:0] sample);
        i_uniform_sample = sample;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        i_valid = 1'b0;
        if (!quiet_phase && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
    endtask

    function automatic logic [UFB:0] random_sample();
        logic [UFB:0] full;
        full = 33'd1 << UFB;
        case ($urandom_range(0, 9))
            0: return {1'($urandom_range(0, 1)), $urandom()};     // any bits, above one too
            1: return (UFB+1)'($urandom_range(1, 255));            // near zero
            2: return full - $urandom_range(1, 255);               // near one
            3: return (full >> 1) + $urandom_range(0, 64) - 32;    // near one half
            default: return {1'b0, $urandom()};
        endcase
    endfunction

    initial begin
        logic [UFB:0] full;
        int wait_cycles;
        full = 33'd1 << UFB;
        quiet_phase = 1'b0;
        i_valid = 1'b0;
        i_uniform_sample = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, one half, above one, all-ones input, near-edge values, quarters, bit patterns
        send_sample(33'd0);
        send_sample(full);
        send_sample(full >> 1);
        send_sample(full + 33'd1);
        send_sample({(UFB+1){1'b1}});
        send_sample(33'd1);
        send_sample(full - 33'd1);
        send_sample(33'd2);
        send_sample(full - 33'd2);
        send_sample((full >> 1) - 33'd1);
        send_sample((full >> 1) + 33'd1);
        send_sample(full >> 2);
        send_sample(33'd3 * (full >> 2));
        send_sample({1'b0, 32'h5555_5555});
        send_sample({1'b0, 32'hAAAA_AAAA});

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
            send_sample(random_sample());
        end

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (60) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+src
src/t2vi_pkg.sv
src/t2vi_stage.sv
src/t2_variate_inversion_unit.sv
src/t2vi_checker.sv
test/t2_variate_inversion_checker.sv
test/t2_variate_inversion_unit_test.sv
